@@ rtl/ogst_pkg.sv @@
package ogst_pkg;

	localparam int EXP_ITERATIONS = 16;
	localparam int LOG2_LAT = EXP_ITERATIONS + 2;
	localparam int EXP_LAT = EXP_ITERATIONS;
	localparam int QBITS = 62;
	localparam int DIV_STEPS = QBITS / 2;
	localparam int DIV_LAT = DIV_STEPS + 1;

	typedef logic [33:0] stretch_t;
	typedef logic [30:0] mant_t;
	typedef logic signed [37:0] lg_t;
	typedef logic signed [45:0] y_t;
	typedef logic signed [13:0] pow_t;
	typedef logic [103:0] prod_t;
	typedef logic [24:0] dvs_t;
	typedef logic [QBITS-1:0] quo_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NONPOS = 2'd1,
		ST_EQUAL  = 2'd2,
		ST_SAT    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_MODULUS = 2'd0,
		CFG_EXP_ONE = 2'd1,
		CFG_EXP_TWO = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic       mode;
		logic       nonpos;
		logic [6:0] kl1;
		logic [6:0] kl2;
	} side_t;

	// 2^(2^-(idx+1)) in Q1.30, each root the floor square root of the one before
	function automatic mant_t root_q30(input int idx);
		logic [63:0] c;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		c = 64'd1 << 31;
		for (int j = 0; j <= idx; j++) begin
			v = c << 30;
			r = '0;
			b = 64'd1 << 62;
			for (int q = 0; q < 32; q++) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			c = r;
		end
		return c[30:0];
	endfunction

endpackage

@@ rtl/ogst_log2.sv @@
module ogst_log2 import ogst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  stretch_t s,
	output logic     out_valid,
	output lg_t      lg
);

	logic       v_s1;
	stretch_t   s_s1;
	logic [5:0] p_s1;
	logic       v_s2;
	mant_t      m_s2;
	logic [5:0] ip_s2;
	logic [5:0] p_c;
	logic [63:0] norm_c;

	logic        sq_v_s  [EXP_ITERATIONS];
	mant_t       sq_m_s  [EXP_ITERATIONS];
	logic [31:0] sq_f_s  [EXP_ITERATIONS];
	logic [5:0]  sq_ip_s [EXP_ITERATIONS];

	// leading one
	always_comb begin
		p_c = '0;
		for (int i = 0; i < 34; i++) begin
			if (s[i]) p_c = 6'(i);
		end
	end

	assign norm_c = {s_s1, 30'b0} >> p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		s_s1  <= s;
		p_s1  <= p_c;
		m_s2  <= norm_c[30:0];
		ip_s2 <= p_s1 - 6'd16;
	end

	// one fraction bit per stage: square the mantissa, renormalize
	for (genvar i = 0; i < EXP_ITERATIONS; i++) begin : g_sq
		logic        src_v;
		mant_t       src_m;
		logic [31:0] src_f;
		logic [5:0]  src_ip;
		logic [61:0] sq;
		logic [31:0] nf;
		mant_t       nm;

		if (i == 0) begin : g_first
			assign src_v  = v_s2;
			assign src_m  = m_s2;
			assign src_f  = '0;
			assign src_ip = ip_s2;
		end else begin : g_next
			assign src_v  = sq_v_s[i-1];
			assign src_m  = sq_m_s[i-1];
			assign src_f  = sq_f_s[i-1];
			assign src_ip = sq_ip_s[i-1];
		end

		assign sq = 62'(src_m) * 62'(src_m);
		assign nm = sq[61] ? sq[61:31] : sq[60:30];

		always_comb begin
			nf = src_f;
			nf[31-i] = sq[61];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[i] <= 1'b0;
			end else begin
				sq_v_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			sq_m_s[i]  <= nm;
			sq_f_s[i]  <= nf;
			sq_ip_s[i] <= src_ip;
		end
	end

	assign out_valid = sq_v_s[EXP_ITERATIONS-1];
	assign lg = lg_t'({sq_ip_s[EXP_ITERATIONS-1], sq_f_s[EXP_ITERATIONS-1]});

endmodule

@@ rtl/ogst_exp2.sv @@
module ogst_exp2 import ogst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  y_t    y,
	output logic  out_valid,
	output mant_t m,
	output pow_t  n
);

	logic  ex_v_s [EXP_LAT];
	mant_t ex_m_s [EXP_LAT];
	y_t    ex_y_s [EXP_LAT];

	// stage i multiplies in 2^(2^-(i+1)) when that fraction bit is set
	for (genvar i = 0; i < EXP_LAT; i++) begin : g_mul
		localparam mant_t ROOT = root_q30(i);
		logic        src_v;
		mant_t       src_m;
		y_t          src_y;
		logic [61:0] pr;
		mant_t       nm;

		if (i == 0) begin : g_first
			assign src_v = in_valid;
			assign src_m = {1'b1, 30'b0};
			assign src_y = y;
		end else begin : g_next
			assign src_v = ex_v_s[i-1];
			assign src_m = ex_m_s[i-1];
			assign src_y = ex_y_s[i-1];
		end

		assign pr = 62'(src_m) * 62'(ROOT);
		assign nm = src_y[31-i] ? pr[60:30] : src_m;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ex_v_s[i] <= 1'b0;
			end else begin
				ex_v_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			ex_m_s[i] <= nm;
			ex_y_s[i] <= src_y;
		end
	end

	assign out_valid = ex_v_s[EXP_LAT-1];
	assign m = ex_m_s[EXP_LAT-1];
	assign n = ex_y_s[EXP_LAT-1][45:32];

endmodule

@@ rtl/ogst_div.sv @@
module ogst_div import ogst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  prod_t num,
	input  dvs_t  den,
	output logic  out_valid,
	output quo_t  quo,
	output logic  ovf
);

	logic  v_s1;
	logic  ovf_s1;
	dvs_t  rem_s1;
	quo_t  lo_s1;

	logic  dv_v_s   [DIV_STEPS];
	logic  dv_ovf_s [DIV_STEPS];
	dvs_t  dv_rem_s [DIV_STEPS];
	quo_t  dv_lo_s  [DIV_STEPS];
	quo_t  dv_q_s   [DIV_STEPS];

	// quotient of 2^62 or more only needs flagging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ovf_s1 <= num[103:62] >= 42'(den);
		rem_s1 <= num[86:62];
		lo_s1  <= num[61:0];
	end

	// restoring division, two quotient bits per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic        src_v;
		logic        src_ovf;
		dvs_t        src_rem;
		quo_t        src_lo;
		quo_t        src_q;
		logic [25:0] r1;
		logic [25:0] r2;
		logic        g1;
		logic        g2;
		dvs_t        a1;
		dvs_t        a2;

		if (j == 0) begin : g_first
			assign src_v   = v_s1;
			assign src_ovf = ovf_s1;
			assign src_rem = rem_s1;
			assign src_lo  = lo_s1;
			assign src_q   = '0;
		end else begin : g_next
			assign src_v   = dv_v_s[j-1];
			assign src_ovf = dv_ovf_s[j-1];
			assign src_rem = dv_rem_s[j-1];
			assign src_lo  = dv_lo_s[j-1];
			assign src_q   = dv_q_s[j-1];
		end

		assign r1 = {src_rem, src_lo[QBITS-1]};
		assign g1 = r1 >= {1'b0, den};
		assign a1 = g1 ? 25'(r1 - {1'b0, den}) : r1[24:0];
		assign r2 = {a1, src_lo[QBITS-2]};
		assign g2 = r2 >= {1'b0, den};
		assign a2 = g2 ? 25'(r2 - {1'b0, den}) : r2[24:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else begin
				dv_v_s[j] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			dv_ovf_s[j] <= src_ovf;
			dv_rem_s[j] <= a2;
			dv_lo_s[j]  <= {src_lo[QBITS-3:0], 2'b00};
			dv_q_s[j]   <= {src_q[QBITS-3:0], g1, g2};
		end
	end

	assign out_valid = dv_v_s[DIV_STEPS-1];
	assign quo = dv_q_s[DIV_STEPS-1];
	assign ovf = dv_ovf_s[DIV_STEPS-1];

endmodule

@@ rtl/ogden_1d_stress_tangent.sv @@
// Two-term Ogden law, 1D: PK2 stress (mode 0) or tangent (mode 1) for one
// axial strain word in signed Q16.16; result in signed Q32.16 with status.
// Input: a word is taken on every clock edge where start is high; busy is
// always low, so a new word may be issued every cycle.
// Output: done pulses for one cycle with value and status; the receiver
// must take it then, it cannot hold the pipeline off.
// Pipeline: one log2 stage per fraction bit, one exp2 multiply per
// fraction bit, and 31 stages of a two-bit-per-stage divider.
// Throughput: one word per cycle.
// Config: cfg_we writes cfg_index (0 modulus, 1 first exponent, 2 second
// exponent) with cfg_data; write only while no word is in flight. Derived
// products settle through the partial-product and ea registers after a write.
// Reset: clears the pipeline valids and loads modulus 1.0 and exponents
// 2.0 and -2.0.
module ogden_1d_stress_tangent import ogst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic signed [31:0] strain,
	output logic               done,
	output logic signed [47:0] value,
	output logic [1:0]         status,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	// configuration
	logic [47:0]        young_q;
	logic signed [23:0] b1_q;
	logic signed [23:0] b2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			young_q <= 48'd65536;
			b1_q    <= 24'sd131072;
			b2_q    <= -24'sd131072;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MODULUS: young_q <= cfg_data;
				CFG_EXP_ONE: b1_q <= cfg_data[23:0];
				CFG_EXP_TWO: b2_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// values derived from configuration, refreshed every cycle
	logic signed [24:0] d_c;
	logic signed [24:0] c1_c;
	logic signed [24:0] c2_c;
	logic [23:0]        ac1_c;
	logic [23:0]        ac2_c;
	logic [71:0]        ea0_c;

	dvs_t               ad_q;
	logic               dneg_q;
	logic               cneg1_q;
	logic               cneg2_q;
	logic [47:0]        pl1_q;
	logic [47:0]        ph1_q;
	logic [47:0]        pl2_q;
	logic [47:0]        ph2_q;
	logic [71:0]        ea1_q;
	logic [71:0]        ea2_q;
	logic signed [25:0] bsh1m0_q;
	logic signed [25:0] bsh1m1_q;
	logic signed [25:0] bsh2m0_q;
	logic signed [25:0] bsh2m1_q;

	assign d_c   = {b1_q[23], b1_q} - {b2_q[23], b2_q};
	assign c1_c  = {b1_q[23], b1_q} - 25'sd131072;
	assign c2_c  = 25'sd131072 - {b2_q[23], b2_q};
	assign ac1_c = c1_c[24] ? 24'(-c1_c) : c1_c[23:0];
	assign ac2_c = c2_c[24] ? 24'(-c2_c) : c2_c[23:0];
	assign ea0_c = {8'b0, young_q, 16'b0};

	always_ff @(posedge clk) begin
		ad_q     <= d_c[24] ? 25'(-d_c) : 25'(d_c);
		dneg_q   <= d_c[24];
		cneg1_q  <= c1_c[24];
		cneg2_q  <= c2_c[24];
		pl1_q    <= 48'(young_q[23:0]) * 48'(ac1_c);
		ph1_q    <= 48'(young_q[47:24]) * 48'(ac1_c);
		pl2_q    <= 48'(young_q[23:0]) * 48'(ac2_c);
		ph2_q    <= 48'(young_q[47:24]) * 48'(ac2_c);
		ea1_q    <= (72'(ph1_q) << 24) + 72'(pl1_q);
		ea2_q    <= (72'(ph2_q) << 24) + 72'(pl2_q);
		bsh1m0_q <= {{2{b1_q[23]}}, b1_q} - 26'sd131072;
		bsh1m1_q <= {{2{b1_q[23]}}, b1_q} - 26'sd262144;
		bsh2m0_q <= {{2{b2_q[23]}}, b2_q} - 26'sd131072;
		bsh2m1_q <= {{2{b2_q[23]}}, b2_q} - 26'sd262144;
	end

	// stage 1: squared stretch
	logic [33:0] s_c;
	logic        v_s1;
	stretch_t    s_s1;
	side_t       side_s1;

	assign s_c = {strain[31], strain, 1'b0} + 34'd65536;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		s_s1           <= s_c;
		side_s1.mode   <= mode;
		side_s1.nonpos <= s_c[33] | (s_c == '0);
		side_s1.kl1    <= '0;
		side_s1.kl2    <= '0;
	end

	// log2
	logic  lg_v;
	lg_t   lg_o;
	side_t side_lg_s [LOG2_LAT];

	ogst_log2 u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.s        (s_s1),
		.out_valid(lg_v),
		.lg       (lg_o)
	);

	always_ff @(posedge clk) begin
		side_lg_s[0] <= side_s1;
		for (int i = 1; i < LOG2_LAT; i++) side_lg_s[i] <= side_lg_s[i-1];
	end

	// exponent times log2, split product
	logic               v_y1;
	logic               v_y2;
	side_t              side_y1;
	side_t              side_y2;
	logic signed [25:0] bsh_c  [2];
	logic signed [45:0] plo_y1 [2];
	logic signed [44:0] phi_y1 [2];
	logic signed [63:0] full_c [2];
	y_t                 y_y2   [2];

	assign bsh_c[0] = side_lg_s[LOG2_LAT-1].mode ? bsh1m1_q : bsh1m0_q;
	assign bsh_c[1] = side_lg_s[LOG2_LAT-1].mode ? bsh2m1_q : bsh2m0_q;

	always_comb begin
		for (int t = 0; t < 2; t++) begin
			full_c[t] = (64'(phi_y1[t]) <<< 19) + 64'(plo_y1[t]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_y1 <= 1'b0;
			v_y2 <= 1'b0;
		end else begin
			v_y1 <= lg_v;
			v_y2 <= v_y1;
		end
	end

	always_ff @(posedge clk) begin
		side_y1 <= side_lg_s[LOG2_LAT-1];
		side_y2 <= side_y1;
		for (int t = 0; t < 2; t++) begin
			plo_y1[t] <= bsh_c[t] * $signed({1'b0, lg_o[18:0]});
			phi_y1[t] <= bsh_c[t] * $signed(lg_o[37:19]);
			y_y2[t]   <= full_c[t][62:17];
		end
	end

	// exp2, one unit per term
	logic  ex_v [2];
	mant_t ex_m [2];
	pow_t  ex_n [2];
	side_t side_ex_s [EXP_LAT];

	for (genvar t = 0; t < 2; t++) begin : g_exp
		ogst_exp2 u_exp2 (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_y2),
			.y        (y_y2[t]),
			.out_valid(ex_v[t]),
			.m        (ex_m[t]),
			.n        (ex_n[t])
		);
	end

	always_ff @(posedge clk) begin
		side_ex_s[0] <= side_y2;
		for (int i = 1; i < EXP_LAT; i++) side_ex_s[i] <= side_ex_s[i-1];
	end

	// E*|c|*mantissa, then the binary-point shift
	logic               v_p1;
	logic               v_p2;
	logic               v_p3;
	side_t              side_p1;
	side_t              side_p2;
	side_t              side_p3;
	logic [71:0]        ea_c   [2];
	logic [54:0]        pp0_p1 [2];
	logic [54:0]        pp1_p1 [2];
	logic [54:0]        pp2_p1 [2];
	logic signed [14:0] k_p1   [2];
	logic signed [14:0] nk_c   [2];
	logic [6:0]         kl_c   [2];
	logic [6:0]         r_c    [2];
	prod_t              p_p2   [2];
	logic [6:0]         r_p2   [2];
	prod_t              d_p3   [2];

	assign ea_c[0] = side_ex_s[EXP_LAT-1].mode ? ea1_q : ea0_c;
	assign ea_c[1] = side_ex_s[EXP_LAT-1].mode ? ea2_q : ea0_c;

	always_comb begin
		for (int t = 0; t < 2; t++) begin
			nk_c[t] = -k_p1[t];
			kl_c[t] = '0;
			r_c[t]  = '0;
			if (k_p1[t] > 15'sd0) begin
				kl_c[t] = (k_p1[t] > 15'sd62) ? 7'd62 : k_p1[t][6:0];
			end else if (k_p1[t] < 15'sd0) begin
				r_c[t] = (nk_c[t] > 15'sd127) ? 7'd127 : nk_c[t][6:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else begin
			v_p1 <= ex_v[0] & ex_v[1];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		side_p1         <= side_ex_s[EXP_LAT-1];
		side_p2.mode    <= side_p1.mode;
		side_p2.nonpos  <= side_p1.nonpos;
		side_p2.kl1     <= kl_c[0];
		side_p2.kl2     <= kl_c[1];
		side_p3         <= side_p2;
		for (int t = 0; t < 2; t++) begin
			pp0_p1[t] <= 55'(ea_c[t][23:0]) * 55'(ex_m[t]);
			pp1_p1[t] <= 55'(ea_c[t][47:24]) * 55'(ex_m[t]);
			pp2_p1[t] <= 55'(ea_c[t][71:48]) * 55'(ex_m[t]);
			k_p1[t]   <= 15'(ex_n[t]) - 15'sd30;
			p_p2[t]   <= 104'(pp0_p1[t]) + (104'(pp1_p1[t]) << 24)
				+ (104'(pp2_p1[t]) << 48);
			r_p2[t]   <= r_c[t];
			d_p3[t]   <= p_p2[t] >> r_p2[t];
		end
	end

	// divide by |b1-b2|
	logic  dv_v   [2];
	quo_t  dv_q   [2];
	logic  dv_ovf [2];
	side_t side_dv_s [DIV_LAT];

	for (genvar t = 0; t < 2; t++) begin : g_div
		ogst_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_p3),
			.num      (d_p3[t]),
			.den      (ad_q),
			.out_valid(dv_v[t]),
			.quo      (dv_q[t]),
			.ovf      (dv_ovf[t])
		);
	end

	always_ff @(posedge clk) begin
		side_dv_s[0] <= side_p3;
		for (int i = 1; i < DIV_LAT; i++) side_dv_s[i] <= side_dv_s[i-1];
	end

	// scale, cap and sign each term
	side_t              sd_c;
	logic [6:0]         kl_f [2];
	logic               cap_c [2];
	logic               neg_c [2];
	logic [61:0]        mag_c [2];
	logic               v_f1;
	side_t              side_f1;
	logic               cap_f1 [2];
	logic signed [62:0] term_f1 [2];

	assign sd_c     = side_dv_s[DIV_LAT-1];
	assign kl_f[0]  = sd_c.kl1;
	assign kl_f[1]  = sd_c.kl2;
	assign neg_c[0] = (sd_c.mode & cneg1_q) ^ dneg_q;
	assign neg_c[1] = (sd_c.mode ? cneg2_q : 1'b1) ^ dneg_q;

	always_comb begin
		for (int t = 0; t < 2; t++) begin
			if (dv_ovf[t]) begin
				cap_c[t] = 1'b1;
			end else if (kl_f[t] >= 7'd62) begin
				cap_c[t] = dv_q[t] != '0;
			end else begin
				cap_c[t] = (dv_q[t] >> (7'd61 - kl_f[t])) != '0;
			end
			mag_c[t] = cap_c[t] ? {1'b1, 61'b0} : (dv_q[t] << kl_f[t]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
		end else begin
			v_f1 <= dv_v[0] & dv_v[1];
		end
	end

	always_ff @(posedge clk) begin
		side_f1 <= sd_c;
		for (int t = 0; t < 2; t++) begin
			cap_f1[t]  <= cap_c[t];
			term_f1[t] <= neg_c[t] ? -$signed({1'b0, mag_c[t]}) : $signed({1'b0, mag_c[t]});
		end
	end

	// sum, clamp, output register
	logic signed [63:0] sum_c;
	logic               hi_c;
	logic               lo_c;
	logic               done_q;
	logic signed [47:0] value_q;
	status_t            status_q;

	assign sum_c = 64'(term_f1[0]) + 64'(term_f1[1]);
	assign hi_c  = sum_c > 64'sh7FFF_FFFF_FFFF;
	assign lo_c  = sum_c < -64'sh8000_0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (side_f1.nonpos) begin
			value_q  <= '0;
			status_q <= ST_NONPOS;
		end else if (b1_q == b2_q) begin
			value_q  <= '0;
			status_q <= ST_EQUAL;
		end else begin
			if (hi_c) value_q <= 48'sh7FFF_FFFF_FFFF;
			else if (lo_c) value_q <= 48'sh8000_0000_0000;
			else value_q <= sum_c[47:0];
			status_q <= (cap_f1[0] | cap_f1[1] | hi_c | lo_c) ? ST_SAT : ST_OK;
		end
	end

	assign done   = done_q;
	assign value  = value_q;
	assign status = status_q;

endmodule

@@ test/ogden_1d_stress_tangent_test.sv @@
module ogden_1d_stress_tangent_test;
	import ogst_pkg::*;

	localparam longint unsigned TERM_CAP = 64'd1 << 61;
	localparam longint LAT_WAIT = 2 * EXP_ITERATIONS + 60;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic        mode;
		logic [31:0] strain;
	} word_t;

	typedef struct {
		logic signed [47:0] value;
		status_t            status;
	} ogden_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic mode = 1'b0;
	logic signed [31:0] strain = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_MODULUS;
	logic [47:0] cfg_data = '0;
	logic busy;
	logic done;
	logic signed [47:0] value;
	logic [1:0] status;

	word_t pending_words[$];
	ogden_out_t expected_outs[$];
	int errors = 0;
	int cycles = 0;
	int gap = 0;

	longint unsigned modulus_copy = 64'd65536;
	longint exp_one_copy = 131072;
	longint exp_two_copy = -131072;

	ogden_1d_stress_tangent dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.strain(strain), .done(done), .value(value), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint stretch_log2(longint unsigned s);
		int p;
		longint unsigned t;
		longint unsigned m;
		longint unsigned frac;
		p = 0;
		t = s;
		frac = 0;
		while (t > 1) begin
			t = t >> 1;
			p++;
		end
		m = (p >= 30) ? (s >> (p - 30)) : (s << (30 - p));
		for (int i = 0; i < EXP_ITERATIONS; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | (64'd1 << (31 - i));
			end
		end
		return (longint'(p - 16) <<< 32) + longint'(frac);
	endfunction

	// mantissa of 2^y in Q1.30; n gets the integer part of y
	function automatic longint unsigned pow2_mant(longint y, output longint n);
		longint unsigned f;
		longint unsigned m;
		longint unsigned c;
		n = y >>> 32;
		f = {32'b0, y[31:0]};
		m = 64'd1 << 30;
		c = 64'd1 << 31;
		for (int i = 0; i < EXP_ITERATIONS; i++) begin
			c = int_sqrt(c << 30);
			if (f[31 - i]) m = (m * c) >> 30;
		end
		return m;
	endfunction

	function automatic longint ogden_term(longint unsigned e, longint c, longint d, longint y,
			inout bit capped);
		logic [127:0] q;
		longint unsigned m;
		longint unsigned ac;
		longint unsigned ad;
		longint unsigned mag;
		longint n;
		longint k;
		int bl;
		bit neg;
		m = pow2_mant(y, n);
		ac = (c < 0) ? -c : c;
		ad = (d < 0) ? -d : d;
		neg = (c < 0) != (d < 0);
		if (ac == 0 || e == 0) return 0;
		q = {64'b0, e} * {64'b0, ac * m};
		q = q / {64'b0, ad};
		k = n - 30;
		if (q == 0) return 0;
		if (k >= 0) begin
			bl = 0;
			for (int i = 0; i < 128; i++) if (q[i]) bl = i + 1;
			if (k > 62 || longint'(bl) + k > 62) mag = TERM_CAP;
			else mag = q[63:0] << k;
		end else begin
			if (-k >= 128) q = '0;
			else q = q >> (-k);
			mag = (q[127:64] != 0 || q[63:0] > TERM_CAP) ? TERM_CAP : q[63:0];
		end
		if (mag >= TERM_CAP) begin
			mag = TERM_CAP;
			capped = 1'b1;
		end
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic ogden_out_t predict_ogden(word_t w);
		ogden_out_t o;
		longint s;
		longint lg;
		longint shift2k;
		longint c1;
		longint c2;
		longint sum;
		bit capped;
		s = 2 * longint'($signed(w.strain)) + 65536;
		o.value = '0;
		o.status = ST_OK;
		capped = 1'b0;
		if (s <= 0) begin
			o.status = ST_NONPOS;
			return o;
		end
		if (exp_one_copy == exp_two_copy) begin
			o.status = ST_EQUAL;
			return o;
		end
		lg = stretch_log2(s);
		shift2k = w.mode ? 4 * 65536 : 2 * 65536;
		if (w.mode) begin
			c1 = exp_one_copy - 2 * 65536;
			c2 = -(exp_two_copy - 2 * 65536);
		end else begin
			c1 = 65536;
			c2 = -65536;
		end
		sum = ogden_term(modulus_copy, c1, exp_one_copy - exp_two_copy,
				((exp_one_copy - shift2k) * lg) >>> 17, capped)
			+ ogden_term(modulus_copy, c2, exp_one_copy - exp_two_copy,
				((exp_two_copy - shift2k) * lg) >>> 17, capped);
		if (capped) o.status = ST_SAT;
		if (sum > (64'sd1 <<< 47) - 1) begin
			sum = (64'sd1 <<< 47) - 1;
			o.status = ST_SAT;
		end
		if (sum < -(64'sd1 <<< 47)) begin
			sum = -(64'sd1 <<< 47);
			o.status = ST_SAT;
		end
		o.value = sum[47:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// driver: word held until accepted, then a random gap
	always @(posedge clk) begin
		word_t w;
		bit accepted;
		if (arst_n) begin
			accepted = start && !busy;
			if (accepted) begin
				w = pending_words.pop_front();
				expected_outs.push_back(predict_ogden(w));
			end
			if (accepted || !start) begin
				if (gap > 0) begin
					gap--;
					start <= 1'b0;
				end else if (pending_words.size() > 0) begin
					mode <= pending_words[0].mode;
					strain <= pending_words[0].strain;
					start <= 1'b1;
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: gap = 0;
						6, 7, 8: gap = $urandom_range(1, 3);
						default: gap = $urandom_range(10, 40);
					endcase
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		ogden_out_t want;
		if (arst_n && done) begin
			if (expected_outs.size() == 0) begin
				report_mismatch("unexpected word, value", value, 0);
			end else begin
				want = expected_outs.pop_front();
				if (value !== want.value) report_mismatch("value", value, want.value);
				if (status !== want.status) report_mismatch("status", status, want.status);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, longint v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[47:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MODULUS: modulus_copy = {16'b0, v[47:0]};
			CFG_EXP_ONE: exp_one_copy = longint'($signed(v[23:0]));
			default: exp_two_copy = longint'($signed(v[23:0]));
		endcase
		repeat (4) @(posedge clk);
	endtask

	task automatic set_params(longint unsigned e, longint b1, longint b2);
		write_reg(CFG_MODULUS, longint'(e));
		write_reg(CFG_EXP_ONE, b1);
		write_reg(CFG_EXP_TWO, b2);
	endtask

	task automatic queue_word(logic md, logic [31:0] st);
		word_t w;
		w.mode = md;
		w.strain = st;
		@(negedge clk);
		pending_words.push_back(w);
	endtask

	// drain: sender holds until every result is back
	task automatic drain();
		@(negedge clk);
		while (pending_words.size() != 0 || start || expected_outs.size() != 0) @(negedge clk);
		repeat (LAT_WAIT) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_strain();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
			2: return -32'd32768 + $urandom_range(0, 16) - 8;
			3: return $urandom_range(0, 32'h7FFFFF);
			default: return $urandom_range(0, 32'h3FFFF) - 32'd32000;
		endcase
	endfunction

	function automatic longint rand_exp();
		if ($urandom_range(0, 4) == 0) return longint'($signed(24'($urandom)));
		return longint'($urandom_range(0, 786432)) - 393216;
	endfunction

	function automatic longint unsigned rand_modulus();
		case ($urandom_range(0, 3))
			0: return {16'b0, 16'($urandom), 32'($urandom)};
			1: return $urandom_range(1, 255);
			default: return $urandom_range(1, 32'hFFFFFF);
		endcase
	endfunction

	initial begin
		logic [31:0] edge_strains[10];
		edge_strains = '{32'h80000000, 32'h7FFFFFFF, 32'hFFFF8000, 32'hFFFF7FFF,
			32'hFFFF8001, 32'h0, 32'h10000, 32'hFFFFFFFF, 32'h1, 32'h00058000};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// reset settings, field extremes, both modes
		foreach (edge_strains[i]) begin
			queue_word(1'b0, edge_strains[i]);
			queue_word(1'b1, edge_strains[i]);
		end
		drain();

		set_params(64'hFFFFFFFFFFFF, 8388607, -8388608);
		foreach (edge_strains[i]) queue_word(i[0], edge_strains[i]);
		drain();

		set_params(1, -8388608, 8388607);
		foreach (edge_strains[i]) queue_word(!i[0], edge_strains[i]);
		drain();

		// equal exponents
		set_params(65536, 196608, 196608);
		for (int i = 0; i < 20; i++) queue_word($urandom_range(0, 1), rand_strain());
		drain();

		// zero modulus
		set_params(0, 131072, -65536);
		for (int i = 0; i < 20; i++) queue_word($urandom_range(0, 1), rand_strain());
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			set_params(rand_modulus(), rand_exp(), rand_exp());
			for (int i = 0; i < 110; i++) queue_word($urandom_range(0, 1), rand_strain());
			drain();
		end

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
